>>> design/gso_pkg.sv
// Package for the 3-D Gram-Schmidt orthonormalizer.
// Holds field widths, payload structs and the Q16 rounding helper.
// No dependencies.
package gso_pkg;

  localparam int IN_W    = 24;  // Q8.16 component width
  localparam int TOL_W   = 16;  // zero-tolerance register width
  localparam int FRAC    = 16;  // fraction bits
  localparam int UNIT_QB = 17;  // quotient bits of a unit component
  localparam int UNIT_W  = 18;  // signed unit component, -65536..65536
  localparam int DOT_W   = 26;  // rounded dot product
  localparam int UNIT_ONE = 65536;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  typedef logic signed [IN_W-1:0]   comp_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef comp_t [2:0] cvec_t;
  typedef unit_t [2:0] uvec_t;

  typedef struct packed {
    comp_t u_x;
    comp_t u_y;
    comp_t u_z;
    comp_t v_x;
    comp_t v_y;
    comp_t v_z;
    comp_t w_x;
    comp_t w_y;
    comp_t w_z;
  } gso_in_t;

  typedef struct packed {
    comp_t ou_x;
    comp_t ou_y;
    comp_t ou_z;
    comp_t ov_x;
    comp_t ov_y;
    comp_t ov_z;
    comp_t ow_x;
    comp_t ow_y;
    comp_t ow_z;
  } gso_out_t;

  // Q.32 -> Q.16, round to nearest, halves away from zero
  function automatic logic signed [47:0] rnd_q16(input logic signed [47:0] x);
    logic [47:0] m;
    logic [47:0] r;
    m = x[47] ? 48'(-x) : 48'(x);
    r = (m + 48'h8000) >> FRAC;
    return x[47] ? -$signed(r) : $signed(r);
  endfunction

endpackage

>>> design/gso_norm.sv
// Pipelined vector normalizer: squares, bit-per-stage square root,
// three bit-per-stage dividers, sign restore. Carries a sideband along.
// Depends on gso_pkg.
module gso_norm
  import gso_pkg::*;
#(
  parameter int RW = IN_W,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [RW-1:0] in_x,
  input  logic signed [RW-1:0] in_y,
  input  logic signed [RW-1:0] in_z,
  input  logic [SW-1:0]        in_side,
  input  logic [TOL_W-1:0]     tol,
  output logic                 out_valid,
  output uvec_t                out_o,
  output logic [SW-1:0]        out_side
);

  localparam int SQ  = 2 * RW;
  localparam int N   = SQ + 2;
  localparam int LW  = RW + 1;
  localparam int PW  = LW + UNIT_QB + 1;
  localparam int CW  = 3 * RW + 3 + SW;
  localparam int NST = LW + UNIT_QB + 4;

  logic [NST-1:0] vld_r;

  logic signed [RW-1:0] r_in [3];
  logic [RW-1:0]        mag  [3];
  logic [2:0]           neg;

  always_comb begin
    r_in[0] = in_x;
    r_in[1] = in_y;
    r_in[2] = in_z;
    for (int i = 0; i < 3; i++) begin
      neg[i] = r_in[i][RW-1];
      mag[i] = neg[i] ? RW'(-r_in[i]) : RW'(r_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[NST-1];

  logic [SQ-1:0] sq0_r [3];
  logic [CW-1:0] c0_r;
  logic [N-1:0]  sn_r   [LW+1];
  logic [N-1:0]  sres_r [LW+1];
  logic [CW-1:0] sc_r   [LW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq0_r[i] <= SQ'(mag[i]) * SQ'(mag[i]);
      end
      c0_r <= {in_side, neg, mag[2], mag[1], mag[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r[0]   <= N'(sq0_r[0]) + N'(sq0_r[1]) + N'(sq0_r[2]);
      sres_r[0] <= '0;
      sc_r[0]   <= c0_r;
    end
  end

  for (genvar k = 0; k < LW; k++) begin : g_sqrt
    localparam logic [N-1:0] BIT = N'(1) << (N - 2 - 2 * k);
    logic [N-1:0] t;
    logic         ge;
    assign t  = sres_r[k] + BIT;
    assign ge = sn_r[k] >= t;
    always_ff @(posedge clk) begin
      if (en) begin
        sn_r[k+1]   <= ge ? sn_r[k] - t : sn_r[k];
        sres_r[k+1] <= ge ? (sres_r[k] >> 1) + BIT : sres_r[k] >> 1;
        sc_r[k+1]   <= sc_r[k];
      end
    end
  end

  logic [PW-1:0]      dp_r    [UNIT_QB+1][3];
  logic [UNIT_QB-1:0] dq_r    [UNIT_QB+1][3];
  logic [LW:0]        dd_r    [UNIT_QB+1];
  logic               dz_r    [UNIT_QB+1];
  logic [2:0]         dneg_r  [UNIT_QB+1];
  logic [SW-1:0]      dside_r [UNIT_QB+1];

  logic [LW-1:0] len;
  logic [CW-1:0] cl;
  assign len = sres_r[LW][LW-1:0];
  assign cl  = sc_r[LW];

  // dividend 2*|c|*2^16 + len, divisor 2*len
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[0][i] <= (PW'(cl[i*RW +: RW]) << (FRAC + 1)) + PW'(len);
        dq_r[0][i] <= '0;
      end
      dd_r[0]    <= {len, 1'b0};
      dz_r[0]    <= len <= LW'(tol);
      dneg_r[0]  <= cl[3*RW +: 3];
      dside_r[0] <= cl[3*RW+3 +: SW];
    end
  end

  for (genvar j = 0; j < UNIT_QB; j++) begin : g_div
    logic [PW-1:0] ds;
    logic [2:0]    ge;
    assign ds = PW'(dd_r[j]) << (UNIT_QB - 1 - j);
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = dp_r[j][i] >= ds;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dp_r[j+1][i] <= ge[i] ? dp_r[j][i] - ds : dp_r[j][i];
          dq_r[j+1][i] <= {dq_r[j][i][UNIT_QB-2:0], ge[i]};
        end
        dd_r[j+1]    <= dd_r[j];
        dz_r[j+1]    <= dz_r[j];
        dneg_r[j+1]  <= dneg_r[j];
        dside_r[j+1] <= dside_r[j];
      end
    end
  end

  uvec_t         o_r;
  logic [SW-1:0] side_r;
  unit_t         qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = unit_t'({1'b0, dq_r[UNIT_QB][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dz_r[UNIT_QB]) begin
          o_r[i] <= '0;
        end else begin
          o_r[i] <= dneg_r[UNIT_QB][i] ? -qs[i] : qs[i];
        end
      end
      side_r <= dside_r[UNIT_QB];
    end
  end

  assign out_o    = o_r;
  assign out_side = side_r;

endmodule

>>> design/gram_schmidt_orthonormalize_3d.sv
// Orthonormalizes three 3-D Q8.16 vectors by classical Gram-Schmidt.
// Top level; depends on gso_pkg and gso_norm.
//
// Usage:
//   in_valid/in_ready/in_data move one set u, v, w (gso_in_t) per transfer.
//   out_valid/out_ready/out_data move the orthonormal set ou, ov, ow.
//   cfg_valid/cfg_ready/cfg_data write the length threshold; cfg_ready is
//   always high. Write it only while the block is empty.
//   The pipeline has 154 register stages: three normalizers of 46, 49
//   and 50 stages (one square-root bit and one quotient bit per stage),
//   eight projection stages, one output register.
//   Throughput is one set per cycle while the pipeline is not stalled.
//   The whole pipeline advances on one enable: when out_valid is high and
//   out_ready low, every stage holds and in_ready drops; bubbles stay.
//   Reset clears all valid bits and sets the length threshold to 1.
module gram_schmidt_orthonormalize_3d
  import gso_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gso_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gso_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data
);

  localparam int R1_W = 27;
  localparam int R2_W = 28;

  typedef struct packed {
    cvec_t w;
    cvec_t v;
  } s1_t;

  typedef struct packed {
    dot_t  d0w;
    cvec_t w;
    uvec_t ou;
  } s2_t;

  typedef struct packed {
    uvec_t ov;
    uvec_t ou;
  } s3_t;

  logic             en;
  logic [TOL_W-1:0] tol_r;
  logic             out_valid_r;
  gso_out_t         out_data_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // first vector
  s1_t   s1_in;
  s1_t   s1;
  logic  n1_valid;
  uvec_t n1_o;
  logic [$bits(s1_t)-1:0] n1_side;

  always_comb begin
    s1_in.v = {in_data.v_z, in_data.v_y, in_data.v_x};
    s1_in.w = {in_data.w_z, in_data.w_y, in_data.w_x};
  end

  gso_norm #(.RW(IN_W), .SW($bits(s1_t))) u_n1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_x     (in_data.u_x),
    .in_y     (in_data.u_y),
    .in_z     (in_data.u_z),
    .in_side  (s1_in),
    .tol      (tol_r),
    .out_valid(n1_valid),
    .out_o    (n1_o),
    .out_side (n1_side)
  );
  assign s1 = s1_t'(n1_side);

  // projection of v and w on ou
  logic [7:0]         pv_r;
  logic signed [41:0] p1v_r [3];
  logic signed [41:0] p1w_r [3];
  uvec_t              p1_ou_r, s1_ou_r, p2_ou_r, r1_ou_r;
  cvec_t              p1_v_r, p1_w_r, s1_v_r, s1_w_r, p2_v_r, p2_w_r, r1_w_r;
  dot_t               s1_d0v_r, s1_d0w_r, p2_d0w_r, r1_d0w_r;
  logic signed [43:0] p2_r [3];
  logic signed [R1_W-1:0] r1_r [3];
  logic signed [47:0] sum1v, sum1w;

  assign sum1v = p1v_r[0] + p1v_r[1] + p1v_r[2];
  assign sum1w = p1w_r[0] + p1w_r[1] + p1w_r[2];

  // second vector
  s2_t   s2_in;
  s2_t   s2;
  logic  n2_valid;
  uvec_t n2_o;
  logic [$bits(s2_t)-1:0] n2_side;

  always_comb begin
    s2_in.d0w = r1_d0w_r;
    s2_in.w   = r1_w_r;
    s2_in.ou  = r1_ou_r;
  end

  gso_norm #(.RW(R1_W), .SW($bits(s2_t))) u_n2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (pv_r[3]),
    .in_x     (r1_r[0]),
    .in_y     (r1_r[1]),
    .in_z     (r1_r[2]),
    .in_side  (s2_in),
    .tol      (tol_r),
    .out_valid(n2_valid),
    .out_o    (n2_o),
    .out_side (n2_side)
  );
  assign s2 = s2_t'(n2_side);

  // projections of w on ou and ov
  logic signed [41:0] p3_r [3];
  uvec_t              p3_ou_r, p3_ov_r, s3_ou_r, s3_ov_r, p4_ou_r, p4_ov_r;
  uvec_t              r2_ou_r, r2_ov_r;
  cvec_t              p3_w_r, s3_w_r, p4_w_r;
  dot_t               p3_d0w_r, s3_d0w_r, s3_d1_r;
  logic signed [43:0] p4a_r [3];
  logic signed [43:0] p4b_r [3];
  logic signed [R2_W-1:0] r2_r [3];
  logic signed [47:0] sum3;

  assign sum3 = p3_r[0] + p3_r[1] + p3_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[6:4], n2_valid, pv_r[2:0], n1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1v_r[i] <= $signed(n1_o[i]) * $signed(s1.v[i]);
        p1w_r[i] <= $signed(n1_o[i]) * $signed(s1.w[i]);
      end
      p1_ou_r <= n1_o;
      p1_v_r  <= s1.v;
      p1_w_r  <= s1.w;

      s1_d0v_r <= DOT_W'(rnd_q16(sum1v));
      s1_d0w_r <= DOT_W'(rnd_q16(sum1w));
      s1_ou_r  <= p1_ou_r;
      s1_v_r   <= p1_v_r;
      s1_w_r   <= p1_w_r;

      for (int i = 0; i < 3; i++) begin
        p2_r[i] <= s1_d0v_r * $signed(s1_ou_r[i]);
      end
      p2_ou_r  <= s1_ou_r;
      p2_v_r   <= s1_v_r;
      p2_w_r   <= s1_w_r;
      p2_d0w_r <= s1_d0w_r;

      for (int i = 0; i < 3; i++) begin
        r1_r[i] <= R1_W'($signed(p2_v_r[i])) - R1_W'(rnd_q16(48'(p2_r[i])));
      end
      r1_ou_r  <= p2_ou_r;
      r1_w_r   <= p2_w_r;
      r1_d0w_r <= p2_d0w_r;

      for (int i = 0; i < 3; i++) begin
        p3_r[i] <= $signed(n2_o[i]) * $signed(s2.w[i]);
      end
      p3_ou_r  <= s2.ou;
      p3_ov_r  <= n2_o;
      p3_w_r   <= s2.w;
      p3_d0w_r <= s2.d0w;

      s3_d1_r  <= DOT_W'(rnd_q16(sum3));
      s3_ou_r  <= p3_ou_r;
      s3_ov_r  <= p3_ov_r;
      s3_w_r   <= p3_w_r;
      s3_d0w_r <= p3_d0w_r;

      for (int i = 0; i < 3; i++) begin
        p4a_r[i] <= s3_d0w_r * $signed(s3_ou_r[i]);
        p4b_r[i] <= s3_d1_r * $signed(s3_ov_r[i]);
      end
      p4_ou_r <= s3_ou_r;
      p4_ov_r <= s3_ov_r;
      p4_w_r  <= s3_w_r;

      for (int i = 0; i < 3; i++) begin
        r2_r[i] <= R2_W'($signed(p4_w_r[i]))
                 - R2_W'(rnd_q16(48'(p4a_r[i]) + 48'(p4b_r[i])));
      end
      r2_ou_r <= p4_ou_r;
      r2_ov_r <= p4_ov_r;
    end
  end

  // third vector
  s3_t   s3_in;
  s3_t   s3;
  logic  n3_valid;
  uvec_t n3_o;
  logic [$bits(s3_t)-1:0] n3_side;

  always_comb begin
    s3_in.ov = r2_ov_r;
    s3_in.ou = r2_ou_r;
  end

  gso_norm #(.RW(R2_W), .SW($bits(s3_t))) u_n3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (pv_r[7]),
    .in_x     (r2_r[0]),
    .in_y     (r2_r[1]),
    .in_z     (r2_r[2]),
    .in_side  (s3_in),
    .tol      (tol_r),
    .out_valid(n3_valid),
    .out_o    (n3_o),
    .out_side (n3_side)
  );
  assign s3 = s3_t'(n3_side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= n3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.ou_x <= IN_W'($signed(s3.ou[0]));
      out_data_r.ou_y <= IN_W'($signed(s3.ou[1]));
      out_data_r.ou_z <= IN_W'($signed(s3.ou[2]));
      out_data_r.ov_x <= IN_W'($signed(s3.ov[0]));
      out_data_r.ov_y <= IN_W'($signed(s3.ov[1]));
      out_data_r.ov_z <= IN_W'($signed(s3.ov[2]));
      out_data_r.ow_x <= IN_W'($signed(n3_o[0]));
      out_data_r.ow_y <= IN_W'($signed(n3_o[1]));
      out_data_r.ow_z <= IN_W'($signed(n3_o[2]));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/gso_chk.sv
// Port-level checker for the Gram-Schmidt block, bound to the top level.
// Depends on gso_pkg.
module gso_chk
  import gso_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input gso_in_t          in_data,
  input logic             out_valid,
  input logic             out_ready,
  input gso_out_t         out_data,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [TOL_W-1:0] cfg_data
);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ou_x <= UNIT_ONE && out_data.ou_x >= -UNIT_ONE &&
                   out_data.ov_y <= UNIT_ONE && out_data.ov_y >= -UNIT_ONE &&
                   out_data.ow_z <= UNIT_ONE && out_data.ow_z >= -UNIT_ONE))
    else $error("unit component out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind gram_schmidt_orthonormalize_3d gso_chk u_gso_chk (.*);

>>> dv/tb_top.sv
// Testbench for gram_schmidt_orthonormalize_3d: streams vector sets through the
// pipeline and compares each orthonormal set with a bit-exact software predictor.
// Depends on gso_pkg and the design sources.
module tb_top;
  import gso_pkg::*;

  localparam int DRAIN_CYC = 170;
  localparam int STALL_LIM = 4000;

  class ortho_board;
    logic [TOL_W-1:0] tol;
    gso_out_t         exp_q[$];
    int               errors;

    function new();
      tol = TOL_RESET;
      errors = 0;
    endfunction

    function longint unsigned mag(longint x);
      return x < 0 ? longint'(0) - x : x;
    endfunction

    function longint rnd16(longint x);
      longint unsigned m;
      m = (mag(x) + 64'd32768) >> FRAC;
      return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void unitize(input longint r[3], output longint o[3]);
      longint unsigned sq;
      longint unsigned len;
      longint unsigned num;
      longint unsigned q;
      sq = 0;
      for (int i = 0; i < 3; i++) sq += mag(r[i]) * mag(r[i]);
      len = root(sq);
      for (int i = 0; i < 3; i++) begin
        if (len > tol) begin
          num = mag(r[i]) << FRAC;
          q = (2 * num + len) / (2 * len);
          o[i] = r[i] < 0 ? -longint'(q) : longint'(q);
        end else begin
          o[i] = 0;
        end
      end
    endfunction

    function longint dot(longint a[3], longint b[3]);
      return rnd16(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
    endfunction

    function void note(gso_in_t d);
      longint u[3], v[3], w[3], ou[3], ov[3], ow[3], r[3];
      longint d0, d1;
      gso_out_t e;
      u = '{d.u_x, d.u_y, d.u_z};
      v = '{d.v_x, d.v_y, d.v_z};
      w = '{d.w_x, d.w_y, d.w_z};
      unitize(u, ou);
      d0 = dot(ou, v);
      for (int i = 0; i < 3; i++) r[i] = v[i] - rnd16(d0 * ou[i]);
      unitize(r, ov);
      d0 = dot(ou, w);
      d1 = dot(ov, w);
      for (int i = 0; i < 3; i++) r[i] = w[i] - rnd16(d0 * ou[i] + d1 * ov[i]);
      unitize(r, ow);
      e.ou_x = comp_t'(ou[0]); e.ou_y = comp_t'(ou[1]); e.ou_z = comp_t'(ou[2]);
      e.ov_x = comp_t'(ov[0]); e.ov_y = comp_t'(ov[1]); e.ov_z = comp_t'(ov[2]);
      e.ow_x = comp_t'(ow[0]); e.ow_y = comp_t'(ow[1]); e.ow_z = comp_t'(ow[2]);
      exp_q.push_back(e);
    endfunction

    function void check(gso_out_t got);
      gso_out_t e;
      logic [9*IN_W-1:0] eb, gb;
      bit bad;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = exp_q.pop_front();
      eb = e;
      gb = got;
      bad = 0;
      for (int f = 0; f < 9; f++)
        if (eb[f*IN_W +: IN_W] !== gb[f*IN_W +: IN_W]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10) $display("mismatch exp %h got %h", e, got);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  gso_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  gso_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data;

  ortho_board sb;
  int snd_idle, rcv_idle;

  gram_schmidt_orthonormalize_3d i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= rcv_idle);
    end
  end

  // result monitor and watchdog
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check(out_data);
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIM) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_set(gso_in_t d);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = d;
    do @(posedge clk); while (!in_ready);
    sb.note(d);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_tol(logic [TOL_W-1:0] t);
    cfg_valid = 1;
    cfg_data = t;
    do @(posedge clk); while (!cfg_ready);
    sb.tol = t;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic comp_t rnd_comp(int mode);
    case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($signed($urandom_range(64)) - 32);
      2: return comp_t'($signed($urandom_range(400000)) - 200000);
      default: return comp_t'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic gso_in_t rnd_set();
    gso_in_t d;
    int mode, shape;
    mode = $urandom_range(3);
    shape = $urandom_range(9);
    d = '{rnd_comp(mode), rnd_comp(mode), rnd_comp(mode),
          rnd_comp(mode), rnd_comp(mode), rnd_comp(mode),
          rnd_comp(mode), rnd_comp(mode), rnd_comp(mode)};
    if (shape == 0) begin          // v nearly parallel to u
      d.v_x = d.u_x + rnd_comp(1);
      d.v_y = d.u_y + rnd_comp(1);
      d.v_z = d.u_z + rnd_comp(1);
    end else if (shape == 1) begin // w nearly in span of u, v
      d.w_x = d.u_x + d.v_x + rnd_comp(1);
      d.w_y = d.u_y + d.v_y + rnd_comp(1);
      d.w_z = d.u_z + d.v_z + rnd_comp(1);
    end else if (shape == 2) begin
      d.u_x = 0; d.u_y = 0; d.u_z = 0;
    end
    return d;
  endfunction

  task automatic run_phase(int n, int si, int ri, logic [TOL_W-1:0] t, bit pause);
    drain();
    write_tol(t);
    snd_idle = si;
    rcv_idle = ri;
    for (int k = 0; k < n; k++) begin
      if (pause && k == n / 2) drain();
      send_set(rnd_set());
    end
  endtask

  localparam comp_t CMAX = 24'sh7FFFFF;
  localparam comp_t CMIN = -24'sh800000;
  localparam comp_t ONE  = 24'sd65536;

  initial begin
    gso_in_t dir[$];
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = '0;
    snd_idle = 11;
    rcv_idle = 76;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    dir.push_back('0);
    dir.push_back('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    dir.push_back('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
    dir.push_back('{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX});
    dir.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    dir.push_back('{CMIN, 0, 0, 0, CMAX, 0, 0, 0, CMIN});
    dir.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    dir.push_back('{2, 0, 0, 0, 2, 0, 0, 0, 2});
    dir.push_back('{ONE, ONE, 0, ONE, ONE, 0, 3, 4, 5});
    dir.push_back('{ONE, 0, 0, 5, 0, 0, 0, 0, 7});
    dir.push_back('{1, 1, 1, -1, -1, -1, 1, 0, -1});
    dir.push_back('{0, 0, 0, ONE, 2, 3, CMAX, CMIN, 1});
    dir.push_back('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 0});
    dir.push_back('{-ONE, -ONE, -ONE, ONE, 0, -ONE, 7, -9, 11});
    dir.push_back('{3, 4, 0, 4, -3, 0, 0, 0, -1});
    dir.push_back('{ONE, 1, 0, ONE, 0, 1, ONE, 1, 1});
    foreach (dir[i]) send_set(dir[i]);

    run_phase(450, 11, 76, 16'd0, 1);
    run_phase(450, 76, 11, 16'hFFFF, 0);
    run_phase(450, 0, 0, 16'($urandom_range(40)), 0);
    drain();

    sb.errors += sb.exp_q.size();
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
design/gso_pkg.sv
design/gso_norm.sv
design/gram_schmidt_orthonormalize_3d.sv
design/gso_chk.sv
dv/tb_top.sv
